### hdl/rvx_pkg.sv
// Shared constants, types and sizes of the RV64 subset execute unit.
package rvx_pkg;

  localparam int MEM_BYTES = 4096;
  localparam int ADDR_W    = $clog2(MEM_BYTES);
  localparam int MEM_ROWS  = MEM_BYTES / 8;
  localparam int ROW_W     = $clog2(MEM_ROWS);
  localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(MEM_ROWS - 1);

  localparam logic [6:0] OPC_REG  = 7'h33;
  localparam logic [6:0] OPC_ADDI = 7'h13;
  localparam logic [6:0] OPC_LD   = 7'h03;
  localparam logic [6:0] OPC_SD   = 7'h23;
  localparam logic [6:0] OPC_BR   = 7'h63;
  localparam logic [6:0] OPC_JAL  = 7'h6F;

  localparam logic [6:0] F7_ADD = 7'h00;
  localparam logic [6:0] F7_SUB = 7'h20;

  localparam logic [2:0] F3_BEQ = 3'h0;
  localparam logic [2:0] F3_BNE = 3'h1;
  localparam logic [2:0] F3_BLT = 3'h4;
  localparam logic [2:0] F3_BGE = 3'h5;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_OPCODE = 2'd1;
  localparam logic [1:0] ST_FUNCT7 = 2'd2;

  typedef struct packed {
    logic [31:0]       npc;
    logic [1:0]        status;
    logic              wr;
    logic [4:0]        rd;
    logic [63:0]       val;
    logic              is_ld;
    logic              is_sd;
    logic [ADDR_W-1:0] addr;
  } ex_res_t;

endpackage

### hdl/rvx_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module rvx_ram #(
  parameter int Width = 8,
  parameter int Depth = 512
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hdl/rvx_exec.sv
// Decode and execute logic: operands and pc in, write, branch and memory request out.
module rvx_exec import rvx_pkg::*; (
  input  logic [31:0] instr_i,
  input  logic [31:0] pc_i,
  input  logic [63:0] rs1_val_i,
  input  logic [63:0] rs2_val_i,
  output ex_res_t     res_o
);

  logic [6:0]  opc;
  logic [4:0]  rd;
  logic [2:0]  f3;
  logic [6:0]  f7;
  logic [63:0] imm_i;
  logic [63:0] imm_s;
  logic [63:0] imm_b;
  logic [63:0] imm_j;
  logic [31:0] pc_plus4;
  logic        take;

  assign opc   = instr_i[6:0];
  assign rd    = instr_i[11:7];
  assign f3    = instr_i[14:12];
  assign f7    = instr_i[31:25];
  assign imm_i = {{52{instr_i[31]}}, instr_i[31:20]};
  assign imm_s = {{52{instr_i[31]}}, instr_i[31:25], instr_i[11:7]};
  assign imm_b = {{51{instr_i[31]}}, instr_i[31], instr_i[7], instr_i[30:25],
                  instr_i[11:8], 1'b0};
  assign imm_j = {{43{instr_i[31]}}, instr_i[31], instr_i[19:12], instr_i[20],
                  instr_i[30:21], 1'b0};
  assign pc_plus4 = pc_i + 32'd4;

  always_comb begin
    case (f3)
      F3_BEQ:  take = (rs1_val_i == rs2_val_i);
      F3_BNE:  take = (rs1_val_i != rs2_val_i);
      F3_BLT:  take = ($signed(rs1_val_i) < $signed(rs2_val_i));
      F3_BGE:  take = !($signed(rs1_val_i) < $signed(rs2_val_i));
      default: take = 1'b0;
    endcase
  end

  always_comb begin
    res_o        = '0;
    res_o.npc    = pc_plus4;
    res_o.rd     = rd;
    res_o.status = ST_OK;
    case (opc)
      OPC_REG: begin
        if (f7 == F7_ADD) begin
          res_o.val = rs1_val_i + rs2_val_i;
          res_o.wr  = 1'b1;
        end else if (f7 == F7_SUB) begin
          res_o.val = rs1_val_i - rs2_val_i;
          res_o.wr  = 1'b1;
        end else begin
          res_o.status = ST_FUNCT7;
        end
      end
      OPC_ADDI: begin
        res_o.val = rs1_val_i + imm_i;
        res_o.wr  = 1'b1;
      end
      OPC_LD: begin
        res_o.wr    = 1'b1;
        res_o.is_ld = (rd != 5'd0);
        res_o.addr  = rs1_val_i[ADDR_W-1:0] + imm_i[ADDR_W-1:0];
      end
      OPC_SD: begin
        res_o.is_sd = 1'b1;
        res_o.addr  = rs1_val_i[ADDR_W-1:0] + imm_s[ADDR_W-1:0];
      end
      OPC_BR: begin
        if (take) begin
          res_o.npc = pc_i + imm_b[31:0];
        end
      end
      OPC_JAL: begin
        res_o.val = {32'd0, pc_plus4};
        res_o.wr  = 1'b1;
        res_o.npc = pc_i + imm_j[31:0];
      end
      default: begin
        res_o.status = ST_OPCODE;
      end
    endcase
    if (!res_o.wr || rd == 5'd0) begin
      res_o.wr  = 1'b0;
      res_o.rd  = 5'd0;
      res_o.val = '0;
    end
  end

endmodule

### hdl/rv64_subset_execute_unit_core.sv
// Top level of the RV64 subset execute unit: register file, data memory and pipeline.
// Stages: input stage, then output stage; out_ready_i low holds a full output stage.
// Throughput: one instruction per cycle unless held; loads and dependent instructions do not stall,
// since results are forwarded from the output stage and the last register file write.
// Reset clears the pc and the register file valid bits at once, then sweeps the data
// memory one 8-byte row a cycle (MEM_BYTES/8 = 512 rows) before taking instructions.
module rv64_subset_execute_unit_core import rvx_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [31:0]        instruction_word_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [31:0]        next_pc_o,
  output logic [1:0]         status_o,
  output logic               reg_written_o,
  output logic [4:0]         dest_index_o,
  output logic signed [63:0] written_value_o
);

  logic              clr_busy_q;
  logic [ROW_W-1:0]  clr_row_q;
  logic [31:0]       pc_q;
  logic [31:0]       rf_valid_q;

  logic              s1_valid_q;
  logic [31:0]       s1_instr_q;

  logic              s2_valid_q;
  logic [31:0]       s2_npc_q;
  logic [1:0]        s2_status_q;
  logic              s2_wr_q;
  logic [4:0]        s2_rd_q;
  logic [63:0]       s2_val_q;
  logic              s2_ld_q;
  logic [2:0]        s2_off_q;

  logic              prev_wr_q;
  logic [4:0]        prev_rd_q;
  logic [63:0]       prev_val_q;

  logic              s2_free;
  logic              s1_adv;
  logic              accept;
  logic              wb_fire;
  logic [63:0]       s2_value;
  logic [63:0]       ld_data;
  logic [63:0]       rf1_rdata;
  logic [63:0]       rf2_rdata;
  logic [4:0]        rs1;
  logic [4:0]        rs2;
  logic [63:0]       op_a;
  logic [63:0]       op_b;
  ex_res_t           ex;
  logic [2:0]        off;
  logic [ROW_W-1:0]  base_row;
  logic [7:0]        lane_rdata [8];
  logic [7:0]        b_bytes [8];

  assign s2_free    = !s2_valid_q || out_ready_i;
  assign s1_adv     = s1_valid_q && s2_free;
  assign in_ready_o = !clr_busy_q && (!s1_valid_q || s2_free);
  assign accept     = in_valid_i && in_ready_o;
  assign wb_fire    = s2_valid_q && out_ready_i && s2_wr_q;
  assign s2_value   = s2_ld_q ? ld_data : s2_val_q;

  assign rs1 = s1_instr_q[19:15];
  assign rs2 = s1_instr_q[24:20];

  rvx_ram #(.Width(64), .Depth(32)) u_rf1 (
    .clk_i   (clk_i),
    .we_i    (wb_fire),
    .waddr_i (s2_rd_q),
    .wdata_i (s2_value),
    .re_i    (accept),
    .raddr_i (instruction_word_i[19:15]),
    .rdata_o (rf1_rdata)
  );

  rvx_ram #(.Width(64), .Depth(32)) u_rf2 (
    .clk_i   (clk_i),
    .we_i    (wb_fire),
    .waddr_i (s2_rd_q),
    .wdata_i (s2_value),
    .re_i    (accept),
    .raddr_i (instruction_word_i[24:20]),
    .rdata_o (rf2_rdata)
  );

  always_comb begin
    if (s2_valid_q && s2_wr_q && s2_rd_q == rs1) begin
      op_a = s2_value;
    end else if (prev_wr_q && prev_rd_q == rs1) begin
      op_a = prev_val_q;
    end else if (rf_valid_q[rs1]) begin
      op_a = rf1_rdata;
    end else begin
      op_a = '0;
    end
    if (s2_valid_q && s2_wr_q && s2_rd_q == rs2) begin
      op_b = s2_value;
    end else if (prev_wr_q && prev_rd_q == rs2) begin
      op_b = prev_val_q;
    end else if (rf_valid_q[rs2]) begin
      op_b = rf2_rdata;
    end else begin
      op_b = '0;
    end
  end

  rvx_exec u_exec (
    .instr_i   (s1_instr_q),
    .pc_i      (pc_q),
    .rs1_val_i (op_a),
    .rs2_val_i (op_b),
    .res_o     (ex)
  );

  assign off      = ex.addr[2:0];
  assign base_row = ex.addr[ADDR_W-1:3];

  for (genvar l = 0; l < 8; l++) begin : g_lane
    logic [ROW_W-1:0] row;
    logic             we;
    logic [ROW_W-1:0] waddr;
    logic [7:0]       wdata;

    assign b_bytes[l] = op_b[8*l +: 8];
    assign row        = base_row + ROW_W'(3'(l) < off);
    assign we         = clr_busy_q || (s1_adv && ex.is_sd);
    assign waddr      = clr_busy_q ? clr_row_q : row;
    assign wdata      = clr_busy_q ? 8'd0 : b_bytes[3'(3'(l) - off)];

    rvx_ram #(.Width(8), .Depth(MEM_ROWS)) u_lane (
      .clk_i   (clk_i),
      .we_i    (we),
      .waddr_i (waddr),
      .wdata_i (wdata),
      .re_i    (s1_adv && ex.is_ld),
      .raddr_i (row),
      .rdata_o (lane_rdata[l])
    );
  end

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      ld_data[8*i +: 8] = lane_rdata[3'(s2_off_q + 3'(i))];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_row_q  <= '0;
      pc_q       <= '0;
      rf_valid_q <= '0;
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      prev_wr_q  <= 1'b0;
    end else begin
      if (clr_busy_q) begin
        clr_row_q <= clr_row_q + ROW_W'(1);
        if (clr_row_q == ROW_LAST) begin
          clr_busy_q <= 1'b0;
        end
      end
      if (accept) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv) begin
        s2_valid_q <= 1'b1;
        pc_q       <= ex.npc;
      end else if (out_ready_i) begin
        s2_valid_q <= 1'b0;
      end
      if (wb_fire) begin
        rf_valid_q[s2_rd_q] <= 1'b1;
        prev_wr_q           <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_instr_q <= instruction_word_i;
    end
    if (s1_adv) begin
      s2_npc_q    <= ex.npc;
      s2_status_q <= ex.status;
      s2_wr_q     <= ex.wr;
      s2_rd_q     <= ex.rd;
      s2_val_q    <= ex.val;
      s2_ld_q     <= ex.is_ld;
      s2_off_q    <= off;
    end
    if (wb_fire) begin
      prev_rd_q  <= s2_rd_q;
      prev_val_q <= s2_value;
    end
  end

  assign out_valid_o     = s2_valid_q;
  assign next_pc_o       = s2_npc_q;
  assign status_o        = s2_status_q;
  assign reg_written_o   = s2_wr_q;
  assign dest_index_o    = s2_rd_q;
  assign written_value_o = $signed(s2_value);

endmodule

### hdl/rvx_checker.sv
// Port-level checks of the execute unit's result beats, bound to the top level.
module rvx_checker import rvx_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic [31:0]        next_pc_o,
  input logic [1:0]         status_o,
  input logic               reg_written_o,
  input logic [4:0]         dest_index_o,
  input logic signed [63:0] written_value_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(next_pc_o))
    else $error("Result beat dropped or changed while stalled.");

  a_no_write_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !reg_written_o |-> dest_index_o == 5'd0 && written_value_o == 64'sd0)
    else $error("Beat without a register write carries a destination or value.");

  a_error_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != ST_OK |-> !reg_written_o)
    else $error("Rejected instruction reports a register write.");

  a_write_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && reg_written_o |-> dest_index_o != 5'd0)
    else $error("Register write reported for register zero.");

endmodule

bind rv64_subset_execute_unit_core rvx_checker u_rvx_checker (.*);

### bench/rvx_exec_checker.sv
// Checker that predicts and compares every result beat of the RV64 subset execute unit.
module rvx_exec_checker import rvx_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  logic [31:0]        instruction_word_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  logic [31:0]        next_pc_i,
  input  logic [1:0]         status_i,
  input  logic               reg_written_i,
  input  logic [4:0]         dest_index_i,
  input  logic signed [63:0] written_value_i,
  output int unsigned        mismatch_count_o,
  output int unsigned        outstanding_o
);

  typedef struct packed {
    logic [31:0] npc;
    logic [1:0]  status;
    logic        wr;
    logic [4:0]  rd;
    logic [63:0] val;
  } retire_t;

  logic [63:0] gpr [32];
  logic [31:0] pc_q;
  logic [7:0]  dmem [MEM_BYTES];
  retire_t     retire_q [$];
  retire_t     retired;
  int unsigned outstanding;
  int unsigned mismatches;

  assign mismatch_count_o = mismatches;
  assign outstanding_o    = outstanding;

  initial mismatches = 0;

  task automatic report(input string field, input logic [63:0] got, input logic [63:0] want);
    if (mismatches < 50) begin
      $display("%0t mismatch on %s: got %h, want %h", $time, field, got, want);
    end
    mismatches++;
  endtask

  task automatic retire_instr(input logic [31:0] w, output retire_t r);
    logic [6:0]        opc;
    logic [4:0]        rd;
    logic [2:0]        f3;
    logic [63:0]       a, b, ea, val;
    logic [63:0]       imm_i, imm_s, imm_b, imm_j;
    logic [31:0]       npc;
    logic [1:0]        st;
    logic              wr, take;
    logic [ADDR_W-1:0] ba;
    opc   = w[6:0];
    rd    = w[11:7];
    f3    = w[14:12];
    a     = (w[19:15] == 5'd0) ? 64'd0 : gpr[w[19:15]];
    b     = (w[24:20] == 5'd0) ? 64'd0 : gpr[w[24:20]];
    imm_i = {{52{w[31]}}, w[31:20]};
    imm_s = {{52{w[31]}}, w[31:25], w[11:7]};
    imm_b = {{51{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
    imm_j = {{43{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
    npc   = pc_q + 32'd4;
    st    = ST_OK;
    wr    = 1'b0;
    take  = 1'b0;
    val   = 64'd0;
    case (opc)
      OPC_REG: begin
        if (w[31:25] == F7_ADD) begin
          val = a + b;
          wr  = 1'b1;
        end else if (w[31:25] == F7_SUB) begin
          val = a - b;
          wr  = 1'b1;
        end else begin
          st = ST_FUNCT7;
        end
      end
      OPC_ADDI: begin
        val = a + imm_i;
        wr  = 1'b1;
      end
      OPC_LD: begin
        if (rd != 5'd0) begin
          ea = a + imm_i;
          for (int k = 0; k < 8; k++) begin
            ba = ea[ADDR_W-1:0] + ADDR_W'(k);
            val[8*k +: 8] = dmem[ba];
          end
          wr = 1'b1;
        end
      end
      OPC_SD: begin
        ea = a + imm_s;
        for (int k = 0; k < 8; k++) begin
          ba = ea[ADDR_W-1:0] + ADDR_W'(k);
          dmem[ba] = b[8*k +: 8];
        end
      end
      OPC_BR: begin
        case (f3)
          F3_BEQ:  take = (a == b);
          F3_BNE:  take = (a != b);
          F3_BLT:  take = ($signed(a) < $signed(b));
          F3_BGE:  take = !($signed(a) < $signed(b));
          default: take = 1'b0;
        endcase
        if (take) npc = pc_q + imm_b[31:0];
      end
      OPC_JAL: begin
        val = {32'd0, pc_q + 32'd4};
        wr  = 1'b1;
        npc = pc_q + imm_j[31:0];
      end
      default: st = ST_OPCODE;
    endcase
    if (wr && rd != 5'd0) begin
      gpr[rd] = val;
    end else begin
      wr  = 1'b0;
      val = 64'd0;
      rd  = 5'd0;
    end
    pc_q     = npc;
    r.npc    = npc;
    r.status = st;
    r.wr     = wr;
    r.rd     = rd;
    r.val    = val;
  endtask

  task automatic check_result();
    retire_t want;
    if (outstanding == 0) begin
      report("unexpected result beat (next_pc)", 64'(next_pc_i), 64'd0);
      return;
    end
    want = retire_q.pop_front();
    outstanding--;
    if (next_pc_i !== want.npc) report("next_pc", 64'(next_pc_i), 64'(want.npc));
    if (status_i !== want.status) report("status", 64'(status_i), 64'(want.status));
    if (reg_written_i !== want.wr) report("reg_written", 64'(reg_written_i), 64'(want.wr));
    if (dest_index_i !== want.rd) report("dest_index", 64'(dest_index_i), 64'(want.rd));
    if (written_value_i !== want.val) report("written_value", written_value_i, want.val);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 32; k++) gpr[k] = 64'd0;
      for (int k = 0; k < MEM_BYTES; k++) dmem[k] = 8'd0;
      pc_q = 32'd0;
      retire_q.delete();
      outstanding = 0;
    end else begin
      if (out_valid_i && out_ready_i) check_result();
      if (in_valid_i && in_ready_i) begin
        retire_instr(instruction_word_i, retired);
        retire_q.push_back(retired);
        outstanding++;
      end
    end
  end

endmodule

### bench/rv64_subset_execute_unit_core_test.sv
// Testbench top of the RV64 subset execute unit: clock, reset, instruction stimulus and verdict.
module rv64_subset_execute_unit_core_test import rvx_pkg::*;;

  localparam int RANDOM_INSTRS = 1350;
  localparam int CALM_INSTRS   = 200;
  localparam int STALL_LIMIT   = 3000;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid = 1'b0;
  logic [31:0]        instruction_word = 32'd0;
  logic               out_ready = 1'b0;
  logic               in_ready_o;
  logic               out_valid_o;
  logic [31:0]        next_pc_o;
  logic [1:0]         status_o;
  logic               reg_written_o;
  logic [4:0]         dest_index_o;
  logic signed [63:0] written_value_o;
  int unsigned        mismatch_count;
  int unsigned        outstanding;
  int unsigned        idle_pct = 0;
  int unsigned        stall_left = 0;
  int unsigned        quiet_cycles = 0;
  logic               calm = 1'b0;

  always #5 clk_i = ~clk_i;

  rv64_subset_execute_unit_core dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid),
    .in_ready_o         (in_ready_o),
    .instruction_word_i (instruction_word),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready),
    .next_pc_o          (next_pc_o),
    .status_o           (status_o),
    .reg_written_o      (reg_written_o),
    .dest_index_o       (dest_index_o),
    .written_value_o    (written_value_o)
  );

  rvx_exec_checker checker_i (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid),
    .in_ready_i         (in_ready_o),
    .instruction_word_i (instruction_word),
    .out_valid_i        (out_valid_o),
    .out_ready_i        (out_ready),
    .next_pc_i          (next_pc_o),
    .status_i           (status_o),
    .reg_written_i      (reg_written_o),
    .dest_index_i       (dest_index_o),
    .written_value_i    (written_value_o),
    .mismatch_count_o   (mismatch_count),
    .outstanding_o      (outstanding)
  );

  function automatic logic [31:0] enc_r(input logic [6:0] f7, input logic [4:0] rs2,
                                        input logic [4:0] rs1, input logic [2:0] f3,
                                        input logic [4:0] rd);
    return {f7, rs2, rs1, f3, rd, OPC_REG};
  endfunction

  function automatic logic [31:0] enc_i(input logic [6:0] opc, input logic [4:0] rd,
                                        input logic [2:0] f3, input logic [4:0] rs1,
                                        input logic [31:0] imm);
    return {imm[11:0], rs1, f3, rd, opc};
  endfunction

  function automatic logic [31:0] enc_s(input logic [4:0] rs2, input logic [4:0] rs1,
                                        input logic [2:0] f3, input logic [31:0] imm);
    return {imm[11:5], rs2, rs1, f3, imm[4:0], OPC_SD};
  endfunction

  function automatic logic [31:0] enc_b(input logic [2:0] f3, input logic [4:0] rs1,
                                        input logic [4:0] rs2, input logic [31:0] imm);
    return {imm[12], imm[10:5], rs2, rs1, f3, imm[4:1], imm[11], OPC_BR};
  endfunction

  function automatic logic [31:0] enc_j(input logic [4:0] rd, input logic [31:0] imm);
    return {imm[20], imm[10:1], imm[11], imm[19:12], rd, OPC_JAL};
  endfunction

  function automatic logic [4:0] pick_reg();
    return ($urandom_range(0, 9) < 7) ? 5'($urandom_range(0, 7)) : 5'($urandom);
  endfunction

  function automatic logic [31:0] rand_instr();
    int unsigned sel;
    logic [4:0]  rd, rs1, rs2;
    logic [2:0]  f3;
    logic [6:0]  f7;
    logic [31:0] imm;
    sel = $urandom_range(0, 99);
    rd  = pick_reg();
    rs1 = pick_reg();
    rs2 = ($urandom_range(0, 4) == 0) ? rs1 : pick_reg();
    f3  = 3'($urandom_range(0, 7));
    imm = $urandom;
    if (sel < 22) begin
      case ($urandom_range(0, 9))
        0:       f7 = 7'($urandom);
        1, 2, 3: f7 = F7_SUB;
        default: f7 = F7_ADD;
      endcase
      return enc_r(f7, rs2, rs1, f3, rd);
    end
    if (sel < 40) return enc_i(OPC_ADDI, rd, f3, rs1, imm);
    if (sel < 70) begin
      // Half of the accesses stay in a small window so that loads see earlier stores.
      if ($urandom_range(0, 1) == 1) begin
        rs1 = 5'd0;
        imm = 32'($urandom_range(0, 160)) - 32'd16;
      end
      if (sel < 55) return enc_i(OPC_LD, rd, f3, rs1, imm);
      return enc_s(rs2, rs1, f3, imm);
    end
    if (sel < 84) begin
      case ($urandom_range(0, 4))
        0:       f3 = F3_BEQ;
        1:       f3 = F3_BNE;
        2:       f3 = F3_BLT;
        3:       f3 = F3_BGE;
        default: f3 = 3'($urandom_range(0, 7));
      endcase
      return enc_b(f3, rs1, rs2, imm);
    end
    if (sel < 89) return enc_j(rd, imm);
    return $urandom;
  endfunction

  task automatic send_instr(input logic [31:0] w);
    if (!calm && $urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
    end
    in_valid         <= 1'b1;
    instruction_word <= w;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk_i);
    while (outstanding != 0) @(negedge clk_i);
  endtask

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else if (stall_left != 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!calm && $urandom_range(0, 99) < idle_pct) begin
      out_ready  <= 1'b0;
      stall_left <= $urandom_range(0, 5);
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && in_ready_o) || (out_valid_o && out_ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    idle_pct = 20;
    send_instr(enc_i(OPC_ADDI, 5'd1, 3'd0, 5'd0, 32'd2047));
    send_instr(enc_i(OPC_ADDI, 5'd2, 3'd0, 5'd0, -32'd2048));
    send_instr(enc_i(OPC_ADDI, 5'd3, 3'd7, 5'd0, -32'd1));
    send_instr(enc_i(OPC_ADDI, 5'd0, 3'd0, 5'd1, 32'd5));
    send_instr(enc_r(F7_ADD, 5'd2, 5'd1, 3'd5, 5'd4));
    send_instr(enc_r(F7_SUB, 5'd1, 5'd2, 3'd0, 5'd5));
    send_instr(enc_r(7'h01, 5'd1, 5'd2, 3'd0, 5'd6));
    send_instr(enc_r(7'h7F, 5'd3, 5'd3, 3'd7, 5'd6));
    send_instr(enc_s(5'd3, 5'd0, 3'd3, -32'd4));
    send_instr(enc_i(OPC_LD, 5'd7, 3'd3, 5'd0, -32'd4));
    send_instr(enc_i(OPC_ADDI, 5'd9, 3'd0, 5'd0, 32'd2045));
    send_instr(enc_s(5'd1, 5'd9, 3'd3, 32'd2047));
    send_instr(enc_i(OPC_LD, 5'd10, 3'd3, 5'd9, 32'd2047));
    send_instr(enc_i(OPC_LD, 5'd0, 3'd3, 5'd0, 32'd0));
    send_instr(enc_i(OPC_LD, 5'd11, 3'd3, 5'd0, 32'd3));
    send_instr(enc_b(F3_BEQ, 5'd1, 5'd1, 32'd8));
    send_instr(enc_b(F3_BNE, 5'd1, 5'd1, 32'd8));
    send_instr(enc_b(F3_BLT, 5'd2, 5'd1, -32'd4));
    send_instr(enc_b(F3_BGE, 5'd2, 5'd1, 32'd12));
    send_instr(enc_b(F3_BGE, 5'd3, 5'd3, -32'd4096));
    send_instr(enc_b(3'd2, 5'd0, 5'd0, 32'd4094));
    send_instr(enc_j(5'd1, 32'h000F_FFFE));
    send_instr(enc_j(5'd0, -32'd1048576));
    send_instr(32'h0000_0000);
    send_instr(32'hFFFF_FFFF);
    send_instr(enc_r(F7_SUB, 5'd3, 5'd0, 3'd0, 5'd12));
    drain();

    for (int n = 0; n < RANDOM_INSTRS; n++) begin
      if (n % 50 == 0) begin
        case ($urandom_range(0, 2))
          0:       idle_pct = 0;
          1:       idle_pct = 10;
          default: idle_pct = 35;
        endcase
      end
      if (n == RANDOM_INSTRS / 2) drain();
      if (n == RANDOM_INSTRS - CALM_INSTRS) calm = 1'b1;
      send_instr(rand_instr());
    end
    drain();

    repeat (8) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
